@@ rtl/core/rasum_pkg.sv @@
// Shared types and constants for the range-add, range-sum tree block.
// No dependencies; used by rasum_bank and range_add_range_sum_tree.
package rasum_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int unsigned SIZE_W       = 11;
  localparam int unsigned NODE_W       = ADDR_W + 2;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IDX_W        = 10;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_BAD_RANGE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD_LO,
    ST_ADD_HI,
    ST_QRY_HI_WALK,
    ST_QRY_HI_MUL,
    ST_QRY_LO_WALK,
    ST_QRY_LO_MUL,
    ST_QRY_SUB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

@@ rtl/core/range_add_range_sum_tree.sv @@
// Range add / range sum over 1024 signed 32-bit elements, held as two Fenwick trees.
// Add: two multiplies, then read-modify-write walks of the update paths at left and right+1.
// Query: walks at right and left-1, each with a multiply, then a subtract; bad range: no walk.
// One item at a time; the next beat is taken in the cycle after the result is loaded.
// Reset (rst, synchronous) runs a clearing pass over all 1024 node addresses; no item is taken then.
// Depends on rasum_pkg and rasum_bank.
module range_add_range_sum_tree (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rasum_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [rasum_pkg::IDX_W-1:0]         left_index,
  input  logic [rasum_pkg::IDX_W-1:0]         right_index,
  input  logic signed [rasum_pkg::DATA_W-1:0] add_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rasum_pkg::DATA_W-1:0] range_total,
  output logic                                status
);

  localparam int unsigned AW = rasum_pkg::ADDR_W;
  localparam int unsigned NW = rasum_pkg::NODE_W;
  localparam int unsigned DW = rasum_pkg::DATA_W;
  localparam int unsigned SW = rasum_pkg::SIZE_W;
  localparam int unsigned IW = rasum_pkg::IDX_W;

  function automatic logic [NW-1:0] low_bit(input logic [NW-1:0] x);
    return x & (~x + NW'(1));
  endfunction

  rasum_pkg::state_t   state, state_next;
  logic [AW-1:0]       clear_addr, clear_addr_next;
  logic                out_valid_next;
  logic [SW-1:0]       size_in_use, size_in_use_next;
  logic                pend, pend_next;

  logic                cmd_r, cmd_r_next;
  logic [IW-1:0]       left_r, left_r_next;
  logic [IW-1:0]       right_r, right_r_next;
  logic [DW-1:0]       value_r, value_r_next;
  logic [NW-1:0]       node, node_next;
  logic [AW-1:0]       pend_addr, pend_addr_next;
  logic [DW-1:0]       slope_delta, slope_delta_next;
  logic [DW-1:0]       offset_delta, offset_delta_next;
  logic [DW-1:0]       acc_s, acc_s_next;
  logic [DW-1:0]       acc_o, acc_o_next;
  logic [DW-1:0]       total, total_next;
  logic                status_r, status_r_next;
  logic [DW-1:0]       prod;
  logic [DW-1:0]       range_total_next;
  logic                status_next;

  logic                prod_en;
  logic [DW-1:0]       mul_a, mul_b, mul_y;
  logic                out_load;
  logic                wr_zero;
  logic [SW-1:0]       n_eff;
  logic                bad_range;
  logic [DW-1:0]       left_m1;

  rasum_pkg::mem_req_t req;
  logic [DW-1:0]       rd_slope, rd_offset;
  logic [DW-1:0]       wr_slope, wr_offset;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != rasum_pkg::ST_IDLE);

  // effective size saturates at the tree capacity, MAX_ELEMENTS
  assign n_eff     = (size_in_use > SW'(rasum_pkg::MAX_ELEMENTS)) ?
                     SW'(rasum_pkg::MAX_ELEMENTS) : size_in_use;
  assign bad_range = (left_index > right_index) || ({1'b0, right_index} >= n_eff);
  assign left_m1   = {{(DW-IW){1'b0}}, left_r} - DW'(1);

  assign wr_slope  = wr_zero ? '0 : rd_slope + slope_delta;
  assign wr_offset = wr_zero ? '0 : rd_offset + offset_delta;

  assign mul_y = mul_a * mul_b;

  rasum_bank u_bank (
    .clk       (clk),
    .req       (req),
    .wr_slope  (wr_slope),
    .wr_offset (wr_offset),
    .rd_slope  (rd_slope),
    .rd_offset (rd_offset)
  );

  // shared multiplier operand selection
  always_comb begin
    mul_a = value_r;
    mul_b = left_m1;
    case (state)
      rasum_pkg::ST_MUL_LO: begin
        mul_a = value_r;
        mul_b = left_m1;
      end
      rasum_pkg::ST_MUL_HI: begin
        mul_a = value_r;
        mul_b = {{(DW-IW){1'b0}}, right_r};
      end
      rasum_pkg::ST_QRY_HI_MUL: begin
        mul_a = acc_s;
        mul_b = {{(DW-IW){1'b0}}, right_r};
      end
      rasum_pkg::ST_QRY_LO_MUL: begin
        mul_a = acc_s;
        mul_b = left_m1;
      end
      default: begin
        mul_a = value_r;
        mul_b = left_m1;
      end
    endcase
  end

  always_comb begin
    state_next        = state;
    clear_addr_next   = clear_addr;
    size_in_use_next  = cfg_valid ? cfg_data : size_in_use;
    pend_next         = 1'b0;
    cmd_r_next        = cmd_r;
    left_r_next       = left_r;
    right_r_next      = right_r;
    value_r_next      = value_r;
    node_next         = node;
    pend_addr_next    = pend_addr;
    slope_delta_next  = slope_delta;
    offset_delta_next = offset_delta;
    acc_s_next        = acc_s;
    acc_o_next        = acc_o;
    total_next        = total;
    status_r_next     = status_r;
    prod_en           = 1'b0;
    out_load          = 1'b0;
    wr_zero           = 1'b0;
    req               = '0;

    case (state)
      rasum_pkg::ST_CLEAR: begin
        req.wr_en       = 1'b1;
        req.wr_addr     = clear_addr;
        wr_zero         = 1'b1;
        clear_addr_next = clear_addr + AW'(1);
        if (clear_addr == AW'(rasum_pkg::MAX_ELEMENTS - 1)) begin
          state_next = rasum_pkg::ST_IDLE;
        end
      end

      rasum_pkg::ST_IDLE: begin
        cmd_r_next   = cmd;
        left_r_next  = left_index;
        right_r_next = right_index;
        value_r_next = $unsigned(add_value);
        acc_s_next   = '0;
        acc_o_next   = '0;
        node_next    = {{(NW-IW){1'b0}}, right_index} + NW'(1);
        if (in_valid) begin
          if (bad_range) begin
            total_next    = '0;
            status_r_next = rasum_pkg::STATUS_BAD_RANGE;
            state_next    = rasum_pkg::ST_DONE;
          end else if (cmd == rasum_pkg::CMD_ADD) begin
            state_next = rasum_pkg::ST_MUL_LO;
          end else begin
            state_next = rasum_pkg::ST_QRY_HI_WALK;
          end
        end
      end

      rasum_pkg::ST_MUL_LO: begin
        prod_en    = 1'b1;
        state_next = rasum_pkg::ST_MUL_HI;
      end

      rasum_pkg::ST_MUL_HI: begin
        offset_delta_next = prod;
        slope_delta_next  = value_r;
        node_next         = {{(NW-IW){1'b0}}, left_r} + NW'(1);
        prod_en           = 1'b1;
        state_next        = rasum_pkg::ST_ADD_LO;
      end

      rasum_pkg::ST_ADD_LO, rasum_pkg::ST_ADD_HI: begin
        // write back the node read last cycle, read the next one on the path
        if (pend) begin
          req.wr_en   = 1'b1;
          req.wr_addr = pend_addr;
        end
        if (node <= {1'b0, n_eff}) begin
          req.rd_en      = 1'b1;
          req.rd_addr    = AW'(node - NW'(1));
          pend_next      = 1'b1;
          pend_addr_next = AW'(node - NW'(1));
          node_next      = node + low_bit(node);
        end else if (state == rasum_pkg::ST_ADD_LO) begin
          node_next         = {{(NW-IW){1'b0}}, right_r} + NW'(2);
          slope_delta_next  = '0 - value_r;
          offset_delta_next = '0 - prod;
          state_next        = rasum_pkg::ST_ADD_HI;
        end else begin
          total_next    = '0;
          status_r_next = rasum_pkg::STATUS_DONE;
          state_next    = rasum_pkg::ST_DONE;
        end
      end

      rasum_pkg::ST_QRY_HI_WALK, rasum_pkg::ST_QRY_LO_WALK: begin
        if (pend) begin
          acc_s_next = acc_s + rd_slope;
          acc_o_next = acc_o + rd_offset;
        end
        if (node != '0) begin
          req.rd_en   = 1'b1;
          req.rd_addr = AW'(node - NW'(1));
          pend_next   = 1'b1;
          node_next   = node - low_bit(node);
        end else if (state == rasum_pkg::ST_QRY_HI_WALK) begin
          state_next = rasum_pkg::ST_QRY_HI_MUL;
        end else begin
          total_next = total + prod;
          state_next = rasum_pkg::ST_QRY_LO_MUL;
        end
      end

      rasum_pkg::ST_QRY_HI_MUL: begin
        prod_en    = 1'b1;
        total_next = '0 - acc_o;
        acc_s_next = '0;
        acc_o_next = '0;
        node_next  = {{(NW-IW){1'b0}}, left_r};
        state_next = rasum_pkg::ST_QRY_LO_WALK;
      end

      rasum_pkg::ST_QRY_LO_MUL: begin
        prod_en    = 1'b1;
        total_next = total + acc_o;
        state_next = rasum_pkg::ST_QRY_SUB;
      end

      rasum_pkg::ST_QRY_SUB: begin
        total_next    = total - prod;
        status_r_next = rasum_pkg::STATUS_DONE;
        state_next    = rasum_pkg::ST_DONE;
      end

      rasum_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = rasum_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rasum_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_next   = out_load || (out_valid && out_stall);
  assign range_total_next = out_load ? total : $unsigned(range_total);
  assign status_next      = out_load ? status_r : status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rasum_pkg::ST_CLEAR;
      clear_addr  <= '0;
      out_valid   <= 1'b0;
      size_in_use <= SW'(1024);
      pend        <= 1'b0;
    end else begin
      state       <= state_next;
      clear_addr  <= clear_addr_next;
      out_valid   <= out_valid_next;
      size_in_use <= size_in_use_next;
      pend        <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_r_next;
    left_r       <= left_r_next;
    right_r      <= right_r_next;
    value_r      <= value_r_next;
    node         <= node_next;
    pend_addr    <= pend_addr_next;
    slope_delta  <= slope_delta_next;
    offset_delta <= offset_delta_next;
    acc_s        <= acc_s_next;
    acc_o        <= acc_o_next;
    total        <= total_next;
    status_r     <= status_r_next;
    range_total  <= $signed(range_total_next);
    status       <= status_next;
    if (prod_en) begin
      prod <= mul_y;
    end
  end

  // the bank is written only by the clearing pass and the update walks
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    req.wr_en |-> (state == rasum_pkg::ST_CLEAR || state == rasum_pkg::ST_ADD_LO ||
                   state == rasum_pkg::ST_ADD_HI))
    else $error("tree bank written outside clear or update");

  // a bad range goes straight to the result, touching no node
  a_bad_skips: assert property (@(posedge clk) disable iff (rst)
    (state == rasum_pkg::ST_IDLE && in_valid && bad_range) |=> state == rasum_pkg::ST_DONE)
    else $error("bad range beat did not go straight to result");

  // a bad-range result always carries a zero total
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rasum_pkg::STATUS_BAD_RANGE) |-> range_total == '0)
    else $error("bad range result with non-zero total");

  // an add item never yields a total
  a_add_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && cmd_r == rasum_pkg::CMD_ADD) |-> total == '0)
    else $error("add item produced a non-zero total");

endmodule

@@ rtl/core/rasum_bank.sv @@
// Node storage for both trees: one write port and one registered read port,
// the two trees sharing addresses. Depends on rasum_pkg.
module rasum_bank (
  input  logic                              clk,
  input  rasum_pkg::mem_req_t               req,
  input  logic [rasum_pkg::DATA_W-1:0]      wr_slope,
  input  logic [rasum_pkg::DATA_W-1:0]      wr_offset,
  output logic [rasum_pkg::DATA_W-1:0]      rd_slope,
  output logic [rasum_pkg::DATA_W-1:0]      rd_offset
);

  logic [rasum_pkg::DATA_W-1:0] slope_mem  [rasum_pkg::MAX_ELEMENTS];
  logic [rasum_pkg::DATA_W-1:0] offset_mem [rasum_pkg::MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slope_mem[req.wr_addr]  <= wr_slope;
      offset_mem[req.wr_addr] <= wr_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_slope  <= slope_mem[req.rd_addr];
      rd_offset <= offset_mem[req.rd_addr];
    end
  end

endmodule
